/* rtl/rephit_pkg.sv */
// Shared constants, types and the sine table function for the rotated ellipse hit test.
package rephit_pkg;

   // Default widths of the query fields.
   localparam int unsigned COORD_BITS_DEF = 16;
   localparam int unsigned ANGLE_BITS_DEF = 12;

   // Fixed field widths.
   localparam int unsigned SEMI_BITS  = 15;
   localparam int unsigned AGE_BITS   = 16;
   localparam int unsigned TRIG_BITS  = 15;
   localparam int unsigned CSR_DATA_BITS = 32;
   localparam int unsigned CSR_INDEX_BITS = 1;

   // Register indexes on the csr port.
   localparam logic [CSR_INDEX_BITS-1:0] REG_ARM_TIME   = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GRAZE_DIST = 1'd1;

   // Register reset values.
   localparam logic [AGE_BITS-1:0]      ARM_TIME_RESET   = 16'd200;
   localparam logic [CSR_DATA_BITS-1:0] GRAZE_DIST_RESET = 32'd0;

   // pi/2 in Q2.30.
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // Sine and cosine of one heading: Q0.15 magnitudes and signs.
   typedef struct packed {
      logic                 sin_neg;
      logic [TRIG_BITS-1:0] sin_mag;
      logic                 cos_neg;
      logic [TRIG_BITS-1:0] cos_mag;
   } trig_type;

   // Quarter-wave sine entry k of a table with 2^qshift steps per quarter turn.
   // Evaluated at elaboration only: Taylor series in Q30, rounded to Q15.
   function automatic logic [TRIG_BITS-1:0] quarter_sine(input logic [63:0] k,
                                                          input int unsigned qshift);
      logic [63:0]        th;
      logic [63:0]        th2;
      logic [63:0]        term;
      logic signed [64:0] sum;
      logic [63:0]        r;
      th   = (k * HALF_PI_Q30) >> qshift;
      th2  = (th * th) >> 30;
      term = th;
      sum  = $signed({1'b0, th});
      term = ((term * th2) >> 30) / 64'd6;
      sum  = sum - $signed({1'b0, term});
      term = ((term * th2) >> 30) / 64'd20;
      sum  = sum + $signed({1'b0, term});
      term = ((term * th2) >> 30) / 64'd42;
      sum  = sum - $signed({1'b0, term});
      term = ((term * th2) >> 30) / 64'd72;
      sum  = sum + $signed({1'b0, term});
      term = ((term * th2) >> 30) / 64'd110;
      sum  = sum - $signed({1'b0, term});
      term = ((term * th2) >> 30) / 64'd156;
      sum  = sum + $signed({1'b0, term});
      term = ((term * th2) >> 30) / 64'd210;
      sum  = sum - $signed({1'b0, term});
      term = ((term * th2) >> 30) / 64'd272;
      sum  = sum + $signed({1'b0, term});
      if (sum < 0) begin
         sum = '0;
      end
      r = (sum[63:0] + 64'd16384) >> 15;
      if (r > 64'd32767) begin
         r = 64'd32767;
      end
      return r[TRIG_BITS-1:0];
   endfunction

endpackage

/* rtl/rephit_sincos.sv */
// Quarter-wave sine ROM with quadrant folding; returns registered sine and cosine.
module rephit_sincos #(
   parameter int unsigned ANGLE_BITS = rephit_pkg::ANGLE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      enable,
   input  logic [ANGLE_BITS-1:0]     heading,
   output rephit_pkg::trig_type      trig
);

   localparam int unsigned QSHIFT  = ANGLE_BITS - 2;
   localparam int unsigned QUARTER = 1 << QSHIFT;
   localparam int unsigned AW      = ANGLE_BITS - 1;
   localparam logic [AW-1:0] QUARTER_ADDR = AW'(QUARTER);

   logic [rephit_pkg::TRIG_BITS-1:0] rom_mem [QUARTER+1];

   // Constant contents, one entry per table step including the quarter point.
   for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
      assign rom_mem[k] = rephit_pkg::quarter_sine(64'(k), QSHIFT);
   end

   logic [1:0]        quad;
   logic [QSHIFT-1:0] idx;
   logic [AW-1:0]     idx_fwd;
   logic [AW-1:0]     idx_rev;
   logic [AW-1:0]     sin_addr;
   logic [AW-1:0]     cos_addr;

   rephit_pkg::trig_type trig_ff;

   // Odd quadrants mirror the quarter wave; cos(h) is sin one quadrant on.
   always_comb begin
      quad     = heading[ANGLE_BITS-1 -: 2];
      idx      = heading[QSHIFT-1:0];
      idx_fwd  = {1'b0, idx};
      idx_rev  = QUARTER_ADDR - idx_fwd;
      sin_addr = quad[0] ? idx_rev : idx_fwd;
      cos_addr = quad[0] ? idx_fwd : idx_rev;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         trig_ff.sin_mag <= rom_mem[sin_addr];
         trig_ff.cos_mag <= rom_mem[cos_addr];
         trig_ff.sin_neg <= quad[1];
         trig_ff.cos_neg <= quad[1] ^ quad[0];
      end
   end

   assign trig = trig_ff;

endmodule

/* rtl/rotated_ellipse_point_hit.sv */
// Top level: pipelined point-in-rotated-ellipse test with one-shot graze report.
//
// One query beat carries a point and one ellipse; one response beat comes back per query,
// in order, with hit, graze_hit and the updated graze flag. The block takes one query beat
// every cycle while the response side does not stall. Eight register stages do the work:
// table read and offset, the four rotation products, the rotated sums, rounding to Q7.12
// magnitudes, the squares, the cross products of the ellipse inequality, the final sums,
// and the compares. The first stage is set by the quarter-wave sine ROM (2^(ANGLE_BITS-2)+1
// entries, read at two addresses each cycle, registered data); the later ones by one
// multiplier or one wide add and compare each. Every stage carries its own valid bit and
// takes a new beat when it is empty or its successor moves, so bubbles close up and a
// stalled response still lets queries enter until the pipe is full. The user must write the
// arm time and graze threshold registers through the csr port only while no query is in
// flight; the block itself does not enforce it.
module rotated_ellipse_point_hit #(
   parameter int unsigned COORD_BITS = rephit_pkg::COORD_BITS_DEF,
   parameter int unsigned ANGLE_BITS = rephit_pkg::ANGLE_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // query channel
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [COORD_BITS-1:0]             req_point_x,
   input  logic signed [COORD_BITS-1:0]             req_point_y,
   input  logic signed [COORD_BITS-1:0]             req_center_x,
   input  logic signed [COORD_BITS-1:0]             req_center_y,
   input  logic [ANGLE_BITS-1:0]                    req_heading,
   input  logic [rephit_pkg::SEMI_BITS-1:0]         req_semi_x,
   input  logic [rephit_pkg::SEMI_BITS-1:0]         req_semi_y,
   input  logic [rephit_pkg::AGE_BITS-1:0]          req_age_ms,
   input  logic                                     req_active,
   input  logic                                     req_graze_checked,
   // response channel
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic                                     rsp_hit,
   output logic                                     rsp_graze_hit,
   output logic                                     rsp_graze_checked_next,
   // register write port
   input  logic                                     csr_write_en,
   input  logic [rephit_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [rephit_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int unsigned STAGES = 8;
   localparam int unsigned SB  = rephit_pkg::SEMI_BITS;
   localparam int unsigned DW  = COORD_BITS + 1;            // offset
   localparam int unsigned TW  = rephit_pkg::TRIG_BITS + 1; // signed sine/cosine
   localparam int unsigned PW  = DW + TW;                   // rotation product
   localparam int unsigned SW  = PW + 1;                    // rotated sum, Q.27
   localparam int unsigned MW  = SW - 15;                   // rounded magnitude, Q.12
   localparam int unsigned QW  = 2 * MW;                    // square of a magnitude
   localparam int unsigned GSW = QW + 1;                    // u^2 + v^2
   localparam int unsigned GW  = (GSW > rephit_pkg::CSR_DATA_BITS) ?
                                 GSW : rephit_pkg::CSR_DATA_BITS;
   localparam int unsigned CW  = (MW > SB) ? MW : SB;       // magnitude vs semi-axis
   localparam int unsigned AW2 = 2 * SB;                    // a^2, b^2, in-range u^2
   localparam int unsigned XW  = 2 * AW2;                   // u^2 b^2 and friends
   localparam int unsigned LW  = XW + 1;                    // their sum
   localparam logic [SW-1:0] RND_HALF = SW'(1) << 14;

   // ---------------- configuration registers ----------------
   logic [rephit_pkg::AGE_BITS-1:0]      arm_time_ff;
   logic [rephit_pkg::CSR_DATA_BITS-1:0] graze_dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         arm_time_ff   <= rephit_pkg::ARM_TIME_RESET;
         graze_dist_ff <= rephit_pkg::GRAZE_DIST_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            rephit_pkg::REG_ARM_TIME:   arm_time_ff   <= csr_wdata[rephit_pkg::AGE_BITS-1:0];
            rephit_pkg::REG_GRAZE_DIST: graze_dist_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- flow control ----------------
   // A stage advances when it is empty or the stage after it advances.
   logic [STAGES:1] valid_ff;
   logic [STAGES:1] go;

   always_comb begin
      go[STAGES] = !valid_ff[STAGES] || !rsp_stall;
      for (int i = STAGES - 1; i >= 1; i--) begin
         go[i] = !valid_ff[i] || go[i+1];
      end
   end

   assign req_stall = !go[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (go[1]) begin
            valid_ff[1] <= req_valid;
         end
         for (int i = 2; i <= STAGES; i++) begin
            if (go[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   // ---------------- stage 1: offsets, arming, table read ----------------
   rephit_pkg::trig_type s1_trig;

   rephit_sincos #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_sincos (
      .clock   (clock),
      .enable  (go[1]),
      .heading (req_heading),
      .trig    (s1_trig)
   );

   logic signed [DW-1:0] s1_dx_in, s1_dy_in;
   logic                 s1_tested_in;

   always_comb begin
      s1_dx_in     = {req_point_x[COORD_BITS-1], req_point_x}
                   - {req_center_x[COORD_BITS-1], req_center_x};
      s1_dy_in     = {req_point_y[COORD_BITS-1], req_point_y}
                   - {req_center_y[COORD_BITS-1], req_center_y};
      s1_tested_in = req_active && (req_age_ms >= arm_time_ff);
   end

   logic signed [DW-1:0] s1_dx_ff, s1_dy_ff;
   logic [SB-1:0]        s1_a_ff, s1_b_ff;
   logic                 s1_tested_ff, s1_checked_ff;

   // ---------------- stage 2: rotation products ----------------
   logic signed [TW-1:0] s2_sin_in, s2_cos_in;

   always_comb begin
      s2_sin_in = s1_trig.sin_neg ? -$signed({1'b0, s1_trig.sin_mag})
                                  :  $signed({1'b0, s1_trig.sin_mag});
      s2_cos_in = s1_trig.cos_neg ? -$signed({1'b0, s1_trig.cos_mag})
                                  :  $signed({1'b0, s1_trig.cos_mag});
   end

   logic signed [PW-1:0] s2_xc_ff, s2_ys_ff, s2_yc_ff, s2_xs_ff;
   logic [SB-1:0]        s2_a_ff, s2_b_ff;
   logic                 s2_tested_ff, s2_checked_ff;

   // ---------------- stage 3: rotated sums ----------------
   logic signed [SW-1:0] s3_u_ff, s3_v_ff;
   logic [SB-1:0]        s3_a_ff, s3_b_ff;
   logic                 s3_tested_ff, s3_checked_ff;

   // ---------------- stage 4: round to Q.12 magnitude, half away from zero ----------------
   logic [SW-1:0] s4_u_rnd_in, s4_v_rnd_in;

   always_comb begin
      s4_u_rnd_in = s3_u_ff[SW-1] ? (RND_HALF - s3_u_ff) : (s3_u_ff + RND_HALF);
      s4_v_rnd_in = s3_v_ff[SW-1] ? (RND_HALF - s3_v_ff) : (s3_v_ff + RND_HALF);
   end

   logic [MW-1:0] s4_um_ff, s4_vm_ff;
   logic [SB-1:0] s4_a_ff, s4_b_ff;
   logic          s4_tested_ff, s4_checked_ff;

   // ---------------- stage 5: squares and range check ----------------
   logic s5_in_range_in;

   always_comb begin
      s5_in_range_in = (CW'(s4_um_ff) < CW'(s4_a_ff)) && (CW'(s4_vm_ff) < CW'(s4_b_ff));
   end

   logic [QW-1:0]  s5_u2_ff, s5_v2_ff;
   logic [AW2-1:0] s5_a2_ff, s5_b2_ff;
   logic           s5_in_range_ff, s5_tested_ff, s5_checked_ff;

   // ---------------- stage 6: cross products and graze sum ----------------
   // When in range, u < a < 2^15, so u^2 fits the narrower hit path.
   logic [XW-1:0]  s6_ub_ff, s6_va_ff, s6_ab_ff;
   logic [GSW-1:0] s6_gsum_ff;
   logic           s6_in_range_ff, s6_tested_ff, s6_checked_ff;

   // ---------------- stage 7: left side sum, graze compare ----------------
   logic [LW-1:0] s7_lhs_ff;
   logic [XW-1:0] s7_ab_ff;
   logic          s7_in_range_ff, s7_tested_ff, s7_checked_ff, s7_graze_ff;

   // ---------------- stage 8: hit compare, response register ----------------
   logic s8_hit_ff, s8_graze_ff, s8_checked_next_ff;

   // Payload registers load with their stage and hold otherwise.
   always_ff @(posedge clock) begin
      if (go[1]) begin
         s1_dx_ff      <= s1_dx_in;
         s1_dy_ff      <= s1_dy_in;
         s1_a_ff       <= req_semi_x;
         s1_b_ff       <= req_semi_y;
         s1_tested_ff  <= s1_tested_in;
         s1_checked_ff <= req_graze_checked;
      end
      if (go[2]) begin
         s2_xc_ff      <= PW'(s1_dx_ff) * PW'(s2_cos_in);
         s2_ys_ff      <= PW'(s1_dy_ff) * PW'(s2_sin_in);
         s2_yc_ff      <= PW'(s1_dy_ff) * PW'(s2_cos_in);
         s2_xs_ff      <= PW'(s1_dx_ff) * PW'(s2_sin_in);
         s2_a_ff       <= s1_a_ff;
         s2_b_ff       <= s1_b_ff;
         s2_tested_ff  <= s1_tested_ff;
         s2_checked_ff <= s1_checked_ff;
      end
      if (go[3]) begin
         s3_u_ff       <= {s2_xc_ff[PW-1], s2_xc_ff} + {s2_ys_ff[PW-1], s2_ys_ff};
         s3_v_ff       <= {s2_yc_ff[PW-1], s2_yc_ff} - {s2_xs_ff[PW-1], s2_xs_ff};
         s3_a_ff       <= s2_a_ff;
         s3_b_ff       <= s2_b_ff;
         s3_tested_ff  <= s2_tested_ff;
         s3_checked_ff <= s2_checked_ff;
      end
      if (go[4]) begin
         s4_um_ff      <= s4_u_rnd_in[SW-1:15];
         s4_vm_ff      <= s4_v_rnd_in[SW-1:15];
         s4_a_ff       <= s3_a_ff;
         s4_b_ff       <= s3_b_ff;
         s4_tested_ff  <= s3_tested_ff;
         s4_checked_ff <= s3_checked_ff;
      end
      if (go[5]) begin
         s5_u2_ff       <= QW'(s4_um_ff) * QW'(s4_um_ff);
         s5_v2_ff       <= QW'(s4_vm_ff) * QW'(s4_vm_ff);
         s5_a2_ff       <= AW2'(s4_a_ff) * AW2'(s4_a_ff);
         s5_b2_ff       <= AW2'(s4_b_ff) * AW2'(s4_b_ff);
         s5_in_range_ff <= s5_in_range_in;
         s5_tested_ff   <= s4_tested_ff;
         s5_checked_ff  <= s4_checked_ff;
      end
      if (go[6]) begin
         s6_ub_ff       <= XW'(AW2'(s5_u2_ff)) * XW'(s5_b2_ff);
         s6_va_ff       <= XW'(AW2'(s5_v2_ff)) * XW'(s5_a2_ff);
         s6_ab_ff       <= XW'(s5_a2_ff) * XW'(s5_b2_ff);
         s6_gsum_ff     <= GSW'(s5_u2_ff) + GSW'(s5_v2_ff);
         s6_in_range_ff <= s5_in_range_ff;
         s6_tested_ff   <= s5_tested_ff;
         s6_checked_ff  <= s5_checked_ff;
      end
      if (go[7]) begin
         s7_lhs_ff      <= LW'(s6_ub_ff) + LW'(s6_va_ff);
         s7_ab_ff       <= s6_ab_ff;
         s7_in_range_ff <= s6_in_range_ff;
         s7_tested_ff   <= s6_tested_ff;
         s7_checked_ff  <= s6_checked_ff;
         // A graze needs an armed test and a flag still clear.
         s7_graze_ff    <= s6_tested_ff && !s6_checked_ff
                        && (GW'(s6_gsum_ff) <= GW'(graze_dist_ff));
      end
      if (go[8]) begin
         s8_hit_ff          <= s7_tested_ff && s7_in_range_ff && (s7_lhs_ff < LW'(s7_ab_ff));
         s8_graze_ff        <= s7_graze_ff;
         s8_checked_next_ff <= s7_checked_ff || s7_graze_ff;
      end
   end

   assign rsp_valid              = valid_ff[STAGES];
   assign rsp_hit                = s8_hit_ff;
   assign rsp_graze_hit          = s8_graze_ff;
   assign rsp_graze_checked_next = s8_checked_next_ff;

endmodule

/* rtl/rephit_checker.sv */
// Port-level assertions for the rotated ellipse hit test, bound to the top level.
module rephit_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_hit,
   input logic rsp_graze_hit,
   input logic rsp_graze_checked_next
);

   // A stalled response beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_graze_hit)
                                && $stable(rsp_graze_checked_next))
      else $error("response beat changed while stalled");

   // A fresh graze always sets the stored flag.
   a_graze_sets_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_graze_hit |-> rsp_graze_checked_next)
      else $error("graze reported without setting the graze flag");

   // A moving response side never holds back queries.
   a_no_stall_when_drained: assert property (@(posedge clock)
      !rsp_stall |-> !req_stall)
      else $error("query stalled while response side moves");

   // Reset empties the pipe.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled query beat stays valid until it is taken.
   a_req_valid_known: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid)
      else $error("query beat withdrawn while stalled");

endmodule

bind rotated_ellipse_point_hit rephit_checker u_rephit_checker (
   .clock                  (clock),
   .reset                  (reset),
   .req_valid              (req_valid),
   .req_stall              (req_stall),
   .rsp_valid              (rsp_valid),
   .rsp_stall              (rsp_stall),
   .rsp_hit                (rsp_hit),
   .rsp_graze_hit          (rsp_graze_hit),
   .rsp_graze_checked_next (rsp_graze_checked_next)
);
